// ===== hw/rtl/tdrl_pkg.sv =====
// shared types, constants and arithmetic helpers for the dipole load assembly block
`timescale 1ns / 1ps
`default_nettype none

package tdrl_pkg;

    localparam int NODE_AW    = 16;
    localparam int ELEM_AW    = 16;
    localparam int COORD_BITS = 20;
    localparam int NODE_DEPTH = 1 << NODE_AW;
    localparam int ELEM_DEPTH = 1 << ELEM_AW;
    localparam int NODE_WORD  = 3 * COORD_BITS;

    localparam logic [2:0] ACT_LOAD_NODE = 3'd0;
    localparam logic [2:0] ACT_LOAD_ELEM = 3'd1;
    localparam logic [2:0] ACT_ADD_SRC   = 3'd2;
    localparam logic [2:0] ACT_READ_ACC  = 3'd3;
    localparam logic [2:0] ACT_CLEAR     = 3'd4;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RDACC,
        ST_GATHER,
        ST_EDGE,
        ST_MAC,
        ST_COF0,
        ST_CHECK,
        ST_DIV,
        ST_SCALE,
        ST_ACC_RD,
        ST_ACC_WR,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MAC_COF,
        MAC_DET,
        MAC_CTB
    } mac_mode_t;

    // edge-vector indices (row*3+col) of the two products of one cofactor
    typedef struct packed {
        logic [3:0] a0;
        logic [3:0] b0;
        logic [3:0] a1;
        logic [3:0] b1;
    } cof_sel_t;

    function automatic cof_sel_t cof_sel(input logic [3:0] ci);
        cof_sel_t r;
        case (ci)
            4'd0:    r = '{4'd4, 4'd8, 4'd7, 4'd5};
            4'd1:    r = '{4'd7, 4'd2, 4'd1, 4'd8};
            4'd2:    r = '{4'd1, 4'd5, 4'd4, 4'd2};
            4'd3:    r = '{4'd6, 4'd5, 4'd3, 4'd8};
            4'd4:    r = '{4'd0, 4'd8, 4'd6, 4'd2};
            4'd5:    r = '{4'd3, 4'd2, 4'd0, 4'd5};
            4'd6:    r = '{4'd3, 4'd7, 4'd6, 4'd4};
            4'd7:    r = '{4'd6, 4'd1, 4'd0, 4'd7};
            4'd8:    r = '{4'd0, 4'd4, 4'd3, 4'd1};
            default: r = '{4'd0, 4'd0, 4'd0, 4'd0};
        endcase
        return r;
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [47:0] mag48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return S64_MAX;
        if (a[63] && b[63] && !s[63]) return S64_MIN;
        return s;
    endfunction

    // arithmetic shift right by 32, saturated to 64 bits
    function automatic logic signed [63:0] shift_sat(input logic signed [127:0] a);
        logic [95:0] sh;
        sh = a[127:32];
        if ((&sh[95:63]) || !(|sh[95:63])) return sh[63:0];
        return sh[95] ? S64_MIN : S64_MAX;
    endfunction

    function automatic logic signed [63:0] mul6_sat(input logic signed [63:0] v);
        logic signed [66:0] p;
        p = (67'(v) <<< 2) + (67'(v) <<< 1);
        if ((&p[66:63]) || !(|p[66:63])) return p[63:0];
        return p[66] ? S64_MIN : S64_MAX;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tet_dipole_rhs_linear.sv =====
// top level: stores, sequencer, shared multiply-accumulate unit and divider lanes
//
// command channel: an item transfers on a rising edge with start high and busy low.
// each result is shown for one cycle with done high; the receiver cannot stall it.
// stores: node coordinates, element vertex lists and accumulators are single-port
// synchronous memories with a registered read.
// clear writes one accumulator per cycle. add source is carried by the one 32x32
// multiply-accumulate unit (each cofactor, the determinant and each vertex share
// in turn), the 64-step divider lanes and one read-modify-write per vertex on the
// accumulator port; it ends after the determinant when the volume is zero.
// one item is worked on at a time; busy stays high until its result is shown;
// loads and unused codes finish without raising busy.
// reset: a clearing pass zeroes all 65536 accumulators with busy high and no
// result; node and element stores hold nothing defined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module tet_dipole_rhs_linear (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [2:0]  action,
    input  wire logic        [15:0] index,
    input  wire logic        [15:0] node_a,
    input  wire logic        [15:0] node_b,
    input  wire logic        [15:0] node_c,
    input  wire logic        [15:0] node_d,
    input  wire logic signed [31:0] val_x,
    input  wire logic signed [31:0] val_y,
    input  wire logic signed [31:0] val_z,
    input  wire logic               last_source,
    output logic                    done,
    output logic signed [63:0]      out_x,
    output logic signed [63:0]      out_y,
    output logic signed [63:0]      out_z,
    output logic                    degenerate,
    output logic                    done_res
);

    localparam int NW = tdrl_pkg::NODE_WORD;
    localparam int CB = tdrl_pkg::COORD_BITS;

    tdrl_pkg::state_t state_reg, state_next;

    // memories
    logic [NW-1:0] node_mem [tdrl_pkg::NODE_DEPTH];
    logic [63:0]   elem_mem [tdrl_pkg::ELEM_DEPTH];
    logic [63:0]   acc_mem  [tdrl_pkg::NODE_DEPTH];

    logic [NW-1:0] node_q_reg;
    logic [63:0]   elem_q_reg;
    logic [63:0]   acc_q_reg;

    logic                        node_we, node_re;
    logic [tdrl_pkg::NODE_AW-1:0] node_addr;
    logic [NW-1:0]               node_wdata;
    logic                        elem_we, elem_re;
    logic [tdrl_pkg::ELEM_AW-1:0] elem_addr;
    logic [63:0]                 elem_wdata;
    logic                        acc_we, acc_re;
    logic [tdrl_pkg::NODE_AW-1:0] acc_addr;
    logic [63:0]                 acc_wdata;

    // control
    logic [tdrl_pkg::NODE_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic                        clr_report_reg, clr_report_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic [3:0]                  item_reg, item_next;
    logic [3:0]                  sub_reg, sub_next;
    tdrl_pkg::mac_mode_t         mode_reg, mode_next;
    logic [5:0]                  div_cnt_reg, div_cnt_next;
    logic                        pvld_reg, pvld_next;
    logic                        done_reg, done_next;

    // payload
    logic signed [31:0]  dip_reg  [3];
    logic signed [31:0]  dip_next [3];
    logic                last_reg, last_next;
    logic signed [CB-1:0] pos_reg  [4][3];
    logic signed [CB-1:0] pos_next [4][3];
    logic signed [CB:0]  e_reg    [9];
    logic signed [CB:0]  e_next   [9];
    logic signed [47:0]  cof_reg  [12];
    logic signed [47:0]  cof_next [12];
    logic signed [63:0]  det_reg, det_next;
    logic signed [63:0]  s_reg    [3];
    logic signed [63:0]  s_next   [3];
    logic [64:0]         rem_reg  [3];
    logic [64:0]         rem_next [3];
    logic [63:0]         quo_reg  [3];
    logic [63:0]         quo_next [3];
    logic                neg_reg  [3];
    logic                neg_next [3];
    logic signed [63:0]  ctb_reg, ctb_next;
    logic [63:0]         prod_reg, prod_next;
    logic [1:0]          psh_reg, psh_next;
    logic                pneg_reg, pneg_next;
    logic signed [127:0] acc_reg, acc_next;
    logic signed [63:0]  out_x_reg, out_x_next;
    logic signed [63:0]  out_y_reg, out_y_next;
    logic signed [63:0]  out_z_reg, out_z_next;
    logic                degen_reg, degen_next;
    logic                done_res_reg, done_res_next;

    logic [3:0] mac_n;
    logic       mac_done;

    assign mac_n    = (mode_reg == tdrl_pkg::MAC_COF) ? 4'd8 : 4'd12;
    assign mac_done = (sub_reg == mac_n) && !pvld_reg;

    function automatic logic [15:0] vnode(input logic [63:0] q, input logic [1:0] sel);
        return q[{sel, 4'b0000} +: 16];
    endfunction

    // memory ports
    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_addr] <= node_wdata;
        end
        if (node_re)
        begin
            node_q_reg <= node_mem[node_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_we)
        begin
            elem_mem[elem_addr] <= elem_wdata;
        end
        if (elem_re)
        begin
            elem_q_reg <= elem_mem[elem_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_addr] <= acc_wdata;
        end
        if (acc_re)
        begin
            acc_q_reg <= acc_mem[acc_addr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tdrl_pkg::ST_CLEAR:
            begin
                if (&clr_cnt_reg) state_next = tdrl_pkg::ST_IDLE;
            end
            tdrl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        tdrl_pkg::ACT_ADD_SRC:  state_next = tdrl_pkg::ST_GATHER;
                        tdrl_pkg::ACT_READ_ACC: state_next = tdrl_pkg::ST_RDACC;
                        tdrl_pkg::ACT_CLEAR:    state_next = tdrl_pkg::ST_CLEAR;
                        default:                state_next = tdrl_pkg::ST_IDLE;
                    endcase
                end
            end
            tdrl_pkg::ST_RDACC:  state_next = tdrl_pkg::ST_IDLE;
            tdrl_pkg::ST_GATHER:
            begin
                if (cnt_reg == 3'd4) state_next = tdrl_pkg::ST_EDGE;
            end
            tdrl_pkg::ST_EDGE:   state_next = tdrl_pkg::ST_MAC;
            tdrl_pkg::ST_MAC:
            begin
                if (mac_done)
                begin
                    unique case (mode_reg)
                        tdrl_pkg::MAC_COF:
                        begin
                            if (item_reg == 4'd8) state_next = tdrl_pkg::ST_COF0;
                        end
                        tdrl_pkg::MAC_DET: state_next = tdrl_pkg::ST_CHECK;
                        tdrl_pkg::MAC_CTB: state_next = tdrl_pkg::ST_ACC_RD;
                        default:           state_next = tdrl_pkg::ST_IDLE;
                    endcase
                end
            end
            tdrl_pkg::ST_COF0:   state_next = tdrl_pkg::ST_MAC;
            tdrl_pkg::ST_CHECK:
            begin
                state_next = (det_reg == '0) ? tdrl_pkg::ST_IDLE : tdrl_pkg::ST_DIV;
            end
            tdrl_pkg::ST_DIV:
            begin
                if (&div_cnt_reg) state_next = tdrl_pkg::ST_SCALE;
            end
            tdrl_pkg::ST_SCALE:  state_next = tdrl_pkg::ST_MAC;
            tdrl_pkg::ST_ACC_RD: state_next = tdrl_pkg::ST_ACC_WR;
            tdrl_pkg::ST_ACC_WR:
            begin
                state_next = (item_reg == 4'd3) ? tdrl_pkg::ST_OUT : tdrl_pkg::ST_MAC;
            end
            tdrl_pkg::ST_OUT:    state_next = tdrl_pkg::ST_IDLE;
            default:             state_next = tdrl_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        tdrl_pkg::cof_sel_t  cs;
        logic [1:0]          term;
        logic [1:0]          pp;
        logic signed [47:0]  ma_s;
        logic signed [63:0]  mb_s;
        logic                mneg;
        logic [47:0]         ma;
        logic [63:0]         mb;
        logic [31:0]         pa;
        logic [31:0]         pb;
        logic                mac_issue;
        logic [127:0]        sh;
        logic [63:0]         magdet;
        logic [64:0]         r;
        logic                ge;

        node_we    = 1'b0;
        node_re    = 1'b0;
        node_addr  = index;
        node_wdata = {val_x[CB-1:0], val_y[CB-1:0], val_z[CB-1:0]};
        elem_we    = 1'b0;
        elem_re    = 1'b0;
        elem_addr  = index;
        elem_wdata = {node_d, node_c, node_b, node_a};
        acc_we     = 1'b0;
        acc_re     = 1'b0;
        acc_addr   = index;
        acc_wdata  = '0;

        clr_cnt_next    = clr_cnt_reg;
        clr_report_next = clr_report_reg;
        cnt_next        = cnt_reg;
        item_next       = item_reg;
        sub_next        = sub_reg;
        mode_next       = mode_reg;
        div_cnt_next    = div_cnt_reg;
        done_next       = 1'b0;
        dip_next        = dip_reg;
        last_next       = last_reg;
        pos_next        = pos_reg;
        e_next          = e_reg;
        cof_next        = cof_reg;
        det_next        = det_reg;
        s_next          = s_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        neg_next        = neg_reg;
        ctb_next        = ctb_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_z_next      = out_z_reg;
        degen_next      = degen_reg;
        done_res_next   = done_res_reg;
        mac_issue       = 1'b0;
        magdet          = tdrl_pkg::mag64(det_reg);
        r               = '0;
        ge              = 1'b0;

        // multiplier operand selection
        term = sub_reg[3:2];
        pp   = sub_reg[1:0];
        cs   = tdrl_pkg::cof_sel(item_reg);
        ma_s = '0;
        mb_s = '0;
        mneg = 1'b0;
        case (mode_reg)
            tdrl_pkg::MAC_COF:
            begin
                if (term == 2'd0)
                begin
                    ma_s = 48'(e_reg[cs.a0]);
                    mb_s = 64'(e_reg[cs.b0]);
                end
                else
                begin
                    ma_s = 48'(e_reg[cs.a1]);
                    mb_s = 64'(e_reg[cs.b1]);
                    mneg = 1'b1;
                end
            end
            tdrl_pkg::MAC_DET:
            begin
                ma_s = 48'(e_reg[4'({2'b00, term} * 4'd3)]);
                mb_s = 64'(cof_reg[4'(4'd3 + {2'b00, term})]);
            end
            default:
            begin
                ma_s = cof_reg[4'(item_reg * 4'd3 + {2'b00, term})];
                mb_s = s_reg[term];
            end
        endcase
        ma = tdrl_pkg::mag48(ma_s);
        mb = tdrl_pkg::mag64(mb_s);
        pa = pp[0] ? {16'b0, ma[47:32]} : ma[31:0];
        pb = pp[1] ? mb[63:32] : mb[31:0];

        unique case (state_reg)
            tdrl_pkg::ST_CLEAR:
            begin
                acc_we       = 1'b1;
                acc_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (&clr_cnt_reg)
                begin
                    clr_report_next = 1'b0;
                    if (clr_report_reg)
                    begin
                        done_next     = 1'b1;
                        out_x_next    = '0;
                        out_y_next    = '0;
                        out_z_next    = '0;
                        degen_next    = 1'b0;
                        done_res_next = 1'b0;
                    end
                end
            end
            tdrl_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    out_x_next    = '0;
                    out_y_next    = '0;
                    out_z_next    = '0;
                    degen_next    = 1'b0;
                    done_res_next = 1'b0;
                    case (action)
                        tdrl_pkg::ACT_LOAD_NODE:
                        begin
                            node_we   = 1'b1;
                            done_next = 1'b1;
                        end
                        tdrl_pkg::ACT_LOAD_ELEM:
                        begin
                            elem_we   = 1'b1;
                            done_next = 1'b1;
                        end
                        tdrl_pkg::ACT_ADD_SRC:
                        begin
                            elem_re     = 1'b1;
                            dip_next[0] = val_x;
                            dip_next[1] = val_y;
                            dip_next[2] = val_z;
                            last_next   = last_source;
                            cnt_next    = '0;
                        end
                        tdrl_pkg::ACT_READ_ACC:
                        begin
                            acc_re = 1'b1;
                        end
                        tdrl_pkg::ACT_CLEAR:
                        begin
                            clr_cnt_next    = '0;
                            clr_report_next = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            tdrl_pkg::ST_RDACC:
            begin
                out_x_next = acc_q_reg;
                done_next  = 1'b1;
            end
            tdrl_pkg::ST_GATHER:
            begin
                // read vertex cnt while capturing vertex cnt-1
                if (cnt_reg != 3'd4)
                begin
                    node_re   = 1'b1;
                    node_addr = vnode(elem_q_reg, cnt_reg[1:0]);
                end
                if (cnt_reg != 3'd0)
                begin
                    pos_next[2'(cnt_reg - 3'd1)][0] = node_q_reg[3*CB-1:2*CB];
                    pos_next[2'(cnt_reg - 3'd1)][1] = node_q_reg[2*CB-1:CB];
                    pos_next[2'(cnt_reg - 3'd1)][2] = node_q_reg[CB-1:0];
                end
                cnt_next = cnt_reg + 3'd1;
            end
            tdrl_pkg::ST_EDGE:
            begin
                for (int rr = 0; rr < 3; rr++)
                begin
                    for (int cc = 0; cc < 3; cc++)
                    begin
                        e_next[rr*3+cc] = (CB+1)'(pos_reg[cc+1][rr]) - (CB+1)'(pos_reg[0][rr]);
                    end
                end
                item_next = '0;
                sub_next  = '0;
                mode_next = tdrl_pkg::MAC_COF;
            end
            tdrl_pkg::ST_MAC:
            begin
                if (sub_reg != mac_n)
                begin
                    mac_issue = 1'b1;
                    sub_next  = sub_reg + 4'd1;
                end
                else if (!pvld_reg)
                begin
                    sub_next = '0;
                    case (mode_reg)
                        tdrl_pkg::MAC_COF:
                        begin
                            cof_next[4'(item_reg + 4'd3)] = acc_reg[47:0];
                            item_next = item_reg + 4'd1;
                        end
                        tdrl_pkg::MAC_DET: det_next = acc_reg[63:0];
                        default:           ctb_next = tdrl_pkg::shift_sat(acc_reg);
                    endcase
                end
            end
            tdrl_pkg::ST_COF0:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    cof_next[k] = -(cof_reg[3+k] + cof_reg[6+k] + cof_reg[9+k]);
                end
                sub_next  = '0;
                mode_next = tdrl_pkg::MAC_DET;
            end
            tdrl_pkg::ST_CHECK:
            begin
                if (det_reg == '0)
                begin
                    out_x_next    = '0;
                    out_y_next    = '0;
                    out_z_next    = '0;
                    degen_next    = 1'b1;
                    done_res_next = last_reg;
                    done_next     = 1'b1;
                end
                else
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        rem_next[k] = '0;
                        quo_next[k] = {tdrl_pkg::mag32(dip_reg[k]), 32'b0};
                        neg_next[k] = dip_reg[k][31] ^ det_reg[63];
                    end
                    div_cnt_next = '0;
                end
            end
            tdrl_pkg::ST_DIV:
            begin
                // restoring division, one quotient bit per lane per cycle
                for (int k = 0; k < 3; k++)
                begin
                    r  = {rem_reg[k][63:0], quo_reg[k][63]};
                    ge = (r >= {1'b0, magdet});
                    rem_next[k] = ge ? (r - {1'b0, magdet}) : r;
                    quo_next[k] = {quo_reg[k][62:0], ge};
                end
                div_cnt_next = div_cnt_reg + 6'd1;
            end
            tdrl_pkg::ST_SCALE:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (neg_reg[k])
                        s_next[k] = quo_reg[k][63] ? tdrl_pkg::S64_MIN : -$signed(quo_reg[k]);
                    else
                        s_next[k] = quo_reg[k][63] ? tdrl_pkg::S64_MAX : $signed(quo_reg[k]);
                end
                item_next = '0;
                sub_next  = '0;
                mode_next = tdrl_pkg::MAC_CTB;
            end
            tdrl_pkg::ST_ACC_RD:
            begin
                acc_re   = 1'b1;
                acc_addr = vnode(elem_q_reg, item_reg[1:0]);
            end
            tdrl_pkg::ST_ACC_WR:
            begin
                acc_we    = 1'b1;
                acc_addr  = vnode(elem_q_reg, item_reg[1:0]);
                acc_wdata = tdrl_pkg::sat_add64(acc_q_reg, ctb_reg);
                item_next = item_reg + 4'd1;
                sub_next  = '0;
            end
            tdrl_pkg::ST_OUT:
            begin
                out_x_next    = tdrl_pkg::mul6_sat(s_reg[0]);
                out_y_next    = tdrl_pkg::mul6_sat(s_reg[1]);
                out_z_next    = tdrl_pkg::mul6_sat(s_reg[2]);
                degen_next    = 1'b0;
                done_res_next = last_reg;
                done_next     = 1'b1;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase

        // partial product stage
        pvld_next = mac_issue;
        prod_next = 64'(pa) * 64'(pb);
        psh_next  = {1'b0, pp[0]} + {1'b0, pp[1]};
        pneg_next = ma_s[47] ^ mb_s[63] ^ mneg;

        // accumulate stage, cleared once a sum has been taken and while idle
        case (psh_reg)
            2'd0:    sh = {64'b0, prod_reg};
            2'd1:    sh = {32'b0, prod_reg, 32'b0};
            default: sh = {prod_reg, 64'b0};
        endcase
        acc_next = acc_reg;
        if (pvld_reg)
        begin
            acc_next = pneg_reg ? (acc_reg - $signed(sh)) : (acc_reg + $signed(sh));
        end
        if ((state_reg == tdrl_pkg::ST_MAC && mac_done) ||
            (state_reg == tdrl_pkg::ST_IDLE))
        begin
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tdrl_pkg::ST_CLEAR;
            clr_cnt_reg    <= '0;
            clr_report_reg <= 1'b0;
            cnt_reg        <= '0;
            item_reg       <= '0;
            sub_reg        <= '0;
            mode_reg       <= tdrl_pkg::MAC_COF;
            div_cnt_reg    <= '0;
            pvld_reg       <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_report_reg <= clr_report_next;
            cnt_reg        <= cnt_next;
            item_reg       <= item_next;
            sub_reg        <= sub_next;
            mode_reg       <= mode_next;
            div_cnt_reg    <= div_cnt_next;
            pvld_reg       <= pvld_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dip_reg      <= dip_next;
        last_reg     <= last_next;
        pos_reg      <= pos_next;
        e_reg        <= e_next;
        cof_reg      <= cof_next;
        det_reg      <= det_next;
        s_reg        <= s_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        neg_reg      <= neg_next;
        ctb_reg      <= ctb_next;
        prod_reg     <= prod_next;
        psh_reg      <= psh_next;
        pneg_reg     <= pneg_next;
        acc_reg      <= acc_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_z_reg    <= out_z_next;
        degen_reg    <= degen_next;
        done_res_reg <= done_res_next;
    end

    assign busy       = (state_reg != tdrl_pkg::ST_IDLE);
    assign done       = done_reg;
    assign out_x      = out_x_reg;
    assign out_y      = out_y_reg;
    assign out_z      = out_z_reg;
    assign degenerate = degen_reg;
    assign done_res   = done_res_reg;

endmodule

`default_nettype wire

// ===== dv/tb_tet_dipole_rhs_linear.sv =====
// testbench for the dipole load assembly block: directed table, then random traffic
`timescale 1ns / 1ps

module tb_tet_dipole_rhs_linear;

    localparam logic [2:0] ACT_SPARE0 = 3'd5;
    localparam logic [2:0] ACT_SPARE1 = 3'd6;
    localparam logic [2:0] ACT_SPARE2 = 3'd7;
    localparam int RANDOM_ITEMS = 850;
    localparam int STALL_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 400;

    typedef struct {
        logic [2:0]         action;
        logic [15:0]        index;
        logic [15:0]        na, nb, nc, nd;
        logic signed [31:0] vx, vy, vz;
        logic               last;
    } cmd_t;

    typedef struct {
        logic signed [63:0] x, y, z;
        logic               degen;
        logic               fin;
    } res_t;

    logic clk, rst_n, start, busy, done;
    logic [2:0] action;
    logic [15:0] index, node_a, node_b, node_c, node_d;
    logic signed [31:0] val_x, val_y, val_z;
    logic last_source;
    logic signed [63:0] out_x, out_y, out_z;
    logic degenerate, done_res;

    tet_dipole_rhs_linear i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .action(action), .index(index),
        .node_a(node_a), .node_b(node_b), .node_c(node_c), .node_d(node_d),
        .val_x(val_x), .val_y(val_y), .val_z(val_z), .last_source(last_source),
        .done(done), .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .degenerate(degenerate), .done_res(done_res)
    );

    // mirror of the block's stores
    logic signed [19:0] crd_x [0:65535];
    logic signed [19:0] crd_y [0:65535];
    logic signed [19:0] crd_z [0:65535];
    logic [15:0]        elem_vtx [0:65535][0:3];
    logic signed [63:0] load_sum [0:65535];
    int nodes_loaded[$];
    int elems_loaded[$];

    res_t expected_res[$];
    int   mismatches;
    int   idle_pct;
    int   quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [63:0] sum_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return tdrl_pkg::S64_MAX;
        if (a[63] && b[63] && !s[63]) return tdrl_pkg::S64_MIN;
        return s;
    endfunction

    // trunc(d * 2^32 / det), saturated
    function automatic logic signed [63:0] inv_volume_scale(input logic signed [63:0] d,
                                                            input logic signed [63:0] det);
        logic [63:0] md, mt, q;
        logic        neg;
        md  = d[63] ? -d : d;
        mt  = det[63] ? -det : det;
        q   = (md << 32) / mt;
        neg = d[63] != det[63];
        if (q[63]) return neg ? tdrl_pkg::S64_MIN : tdrl_pkg::S64_MAX;
        return neg ? -q : q;
    endfunction

    function automatic logic signed [63:0] times_six(input logic signed [63:0] v);
        if (v > tdrl_pkg::S64_MAX / 6) return tdrl_pkg::S64_MAX;
        if (v < tdrl_pkg::S64_MIN / 6) return tdrl_pkg::S64_MIN;
        return v * 6;
    endfunction

    function automatic res_t assemble(input cmd_t c);
        res_t               r;
        logic signed [63:0] p [0:3][0:2];
        logic signed [63:0] e [0:2][0:2];
        logic signed [63:0] cf [0:3][0:2];
        logic signed [63:0] s [0:2];
        logic signed [63:0] det;
        logic signed [127:0] acc, wa, wb, sh;
        logic signed [63:0] share;
        r = '{64'sd0, 64'sd0, 64'sd0, 1'b0, 1'b0};
        case (c.action)
            tdrl_pkg::ACT_LOAD_NODE:
            begin
                crd_x[c.index] = c.vx[19:0];
                crd_y[c.index] = c.vy[19:0];
                crd_z[c.index] = c.vz[19:0];
            end
            tdrl_pkg::ACT_LOAD_ELEM:
            begin
                elem_vtx[c.index][0] = c.na;
                elem_vtx[c.index][1] = c.nb;
                elem_vtx[c.index][2] = c.nc;
                elem_vtx[c.index][3] = c.nd;
            end
            tdrl_pkg::ACT_READ_ACC: r.x = load_sum[c.index];
            tdrl_pkg::ACT_CLEAR: for (int n = 0; n < 65536; n++) load_sum[n] = 64'sd0;
            tdrl_pkg::ACT_ADD_SRC:
            begin
                r.fin = c.last;
                for (int v = 0; v < 4; v++)
                begin
                    p[v][0] = crd_x[elem_vtx[c.index][v]];
                    p[v][1] = crd_y[elem_vtx[c.index][v]];
                    p[v][2] = crd_z[elem_vtx[c.index][v]];
                end
                for (int k = 0; k < 3; k++)
                    for (int v = 0; v < 3; v++) e[k][v] = p[v + 1][k] - p[0][k];
                cf[1][0] = e[1][1] * e[2][2] - e[2][1] * e[1][2];
                cf[1][1] = e[2][1] * e[0][2] - e[0][1] * e[2][2];
                cf[1][2] = e[0][1] * e[1][2] - e[1][1] * e[0][2];
                cf[2][0] = e[2][0] * e[1][2] - e[1][0] * e[2][2];
                cf[2][1] = e[0][0] * e[2][2] - e[2][0] * e[0][2];
                cf[2][2] = e[1][0] * e[0][2] - e[0][0] * e[1][2];
                cf[3][0] = e[1][0] * e[2][1] - e[2][0] * e[1][1];
                cf[3][1] = e[2][0] * e[0][1] - e[0][0] * e[2][1];
                cf[3][2] = e[0][0] * e[1][1] - e[1][0] * e[0][1];
                for (int k = 0; k < 3; k++) cf[0][k] = -cf[1][k] - cf[2][k] - cf[3][k];
                det = e[0][0] * cf[1][0] + e[1][0] * cf[1][1] + e[2][0] * cf[1][2];
                if (det == 0)
                begin
                    r.degen = 1'b1;
                end
                else
                begin
                    s[0] = inv_volume_scale(c.vx, det);
                    s[1] = inv_volume_scale(c.vy, det);
                    s[2] = inv_volume_scale(c.vz, det);
                    // repeated vertices each add their share in order
                    for (int v = 0; v < 4; v++)
                    begin
                        acc = 128'sd0;
                        for (int k = 0; k < 3; k++)
                        begin
                            wa  = cf[v][k];
                            wb  = s[k];
                            acc = acc + wa * wb;
                        end
                        sh = acc >>> 32;
                        if ((&sh[127:63]) || !(|sh[127:63])) share = sh[63:0];
                        else share = sh[127] ? tdrl_pkg::S64_MIN : tdrl_pkg::S64_MAX;
                        load_sum[elem_vtx[c.index][v]] =
                            sum_sat(load_sum[elem_vtx[c.index][v]], share);
                    end
                    r.x = times_six(s[0]);
                    r.y = times_six(s[1]);
                    r.z = times_six(s[2]);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic cmd_t mk(input logic [2:0] a, input logic [15:0] idx,
                                input logic [15:0] n0, n1, n2, n3,
                                input logic [31:0] x, y, z, input logic l);
        cmd_t c;
        c = '{a, idx, n0, n1, n2, n3, x, y, z, l};
        return c;
    endfunction

    task automatic send(input cmd_t c, input bit typed, input res_t want);
        res_t r;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        action <= c.action; index <= c.index;
        node_a <= c.na; node_b <= c.nb; node_c <= c.nc; node_d <= c.nd;
        val_x <= c.vx; val_y <= c.vy; val_z <= c.vz; last_source <= c.last;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        r = assemble(c);
        expected_res.push_back(typed ? want : r);
        if (c.action == tdrl_pkg::ACT_LOAD_NODE) nodes_loaded.push_back(c.index);
        if (c.action == tdrl_pkg::ACT_LOAD_ELEM) elems_loaded.push_back(c.index);
    endtask

    // result check
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_res.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result out_x=%0d", out_x);
            end
            else
            begin
                res_t w;
                w = expected_res.pop_front();
                if (out_x !== w.x || out_y !== w.y || out_z !== w.z ||
                    degenerate !== w.degen || done_res !== w.fin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d %0b %0b, got %0d %0d %0d %0b %0b",
                                 w.x, w.y, w.z, w.degen, w.fin,
                                 out_x, out_y, out_z, degenerate, done_res);
                end
            end
        end
    end

    // watchdog on cycles without a transfer
    always @(posedge clk)
    begin
        if (start && !busy) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        logic [19:0] cv;
        cv = ($urandom_range(99) < 70) ? 20'($urandom_range(200) - 100) : 20'($urandom);
        return {12'($urandom), cv};
    endfunction

    initial
    begin
        res_t  z0, dg;
        cmd_t  c;
        int    pick;
        logic [15:0] vtx [0:3];
        mismatches   = 0;
        quiet_cycles = 0;
        idle_pct     = 0;
        rst_n = 1'b0; start = 1'b0; action = tdrl_pkg::ACT_LOAD_NODE; index = '0;
        node_a = '0; node_b = '0; node_c = '0; node_d = '0;
        val_x = '0; val_y = '0; val_z = '0; last_source = 1'b0;
        for (int n = 0; n < 65536; n++) load_sum[n] = 64'sd0;
        z0 = '{64'sd0, 64'sd0, 64'sd0, 1'b0, 1'b0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: typed results where they are obvious
        begin
            cmd_t tbl_cmd[$];
            bit   tbl_typed[$];
            res_t tbl_res[$];
            dg = '{64'sd0, 64'sd0, 64'sd0, 1'b1, 1'b1};
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_READ_ACC, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0));
            tbl_typed.push_back(1); tbl_res.push_back(z0);
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_READ_ACC, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1));
            tbl_typed.push_back(1); tbl_res.push_back(z0);
            tbl_cmd.push_back(mk(ACT_SPARE0, 16'd5, 1, 2, 3, 4, 7, 8, 9, 1));
            tbl_typed.push_back(1); tbl_res.push_back(z0);
            tbl_cmd.push_back(mk(ACT_SPARE1, 16'd6, 0, 0, 0, 0, 0, 0, 0, 0));
            tbl_typed.push_back(1); tbl_res.push_back(z0);
            tbl_cmd.push_back(mk(ACT_SPARE2, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 1));
            tbl_typed.push_back(1); tbl_res.push_back(z0);
            // large tetrahedron at the coordinate extremes, upper bits ignored
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_LOAD_NODE, 16'd0, 0, 0, 0, 0,
                                 32'hFFF00000, 32'hFFF00000, 32'hFFF00000, 0));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_LOAD_NODE, 16'd1, 0, 0, 0, 0,
                                 32'h0007FFFF, 0, 0, 0));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_LOAD_NODE, 16'd2, 0, 0, 0, 0,
                                 0, 32'h0007FFFF, 0, 0));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_LOAD_NODE, 16'd3, 0, 0, 0, 0,
                                 0, 0, 32'h00080000, 0));
            // unit tetrahedron: smallest volume, scaled dipole saturates
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_LOAD_NODE, 16'd4, 0, 0, 0, 0, 0, 0, 0, 0));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_LOAD_NODE, 16'd5, 0, 0, 0, 0, 1, 0, 0, 0));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_LOAD_NODE, 16'd6, 0, 0, 0, 0, 0, 1, 0, 0));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_LOAD_NODE, 16'hFFFF, 0, 0, 0, 0, 0, 0, 1, 0));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_LOAD_ELEM, 16'd0, 0, 1, 2, 3, 0, 0, 0, 0));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_LOAD_ELEM, 16'd1, 4, 5, 6, 16'hFFFF,
                                 0, 0, 0, 0));
            // repeated node gives zero volume
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_LOAD_ELEM, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4, 5,
                                 0, 0, 0, 0));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_ADD_SRC, 16'd0, 0, 0, 0, 0,
                                 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 0));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_ADD_SRC, 16'd1, 0, 0, 0, 0,
                                 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 1));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_ADD_SRC, 16'hFFFF, 0, 0, 0, 0,
                                 32'h00010000, 1, 2, 1));
            for (int k = 5; k < tbl_cmd.size(); k++)
            begin
                tbl_typed.push_back(tbl_cmd[k].index == 16'hFFFF &&
                                    tbl_cmd[k].action == tdrl_pkg::ACT_ADD_SRC);
                tbl_res.push_back(dg);
            end
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_READ_ACC, 16'd0, 0, 0, 0, 0, 0, 0, 0, 0));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_READ_ACC, 16'd4, 0, 0, 0, 0, 0, 0, 0, 0));
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_READ_ACC, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
            repeat (3)
            begin
                tbl_typed.push_back(0); tbl_res.push_back(z0);
            end
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_CLEAR, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0));
            tbl_typed.push_back(1); tbl_res.push_back(z0);
            tbl_cmd.push_back(mk(tdrl_pkg::ACT_READ_ACC, 16'd4, 0, 0, 0, 0, 0, 0, 0, 0));
            tbl_typed.push_back(1); tbl_res.push_back(z0);
            for (int k = 0; k < tbl_cmd.size(); k++) send(tbl_cmd[k], tbl_typed[k], tbl_res[k]);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idle_pct = (i < 212) ? 0 : (i < 425) ? 58 : (i < 637) ? 19 : 0;
            if (i == 400)
            begin
                // hold off until the block has drained
                start <= 1'b0;
                while (expected_res.size() != 0) @(posedge clk);
            end
            if (i == 300 || i == 700)
            begin
                c = mk(tdrl_pkg::ACT_CLEAR, 16'($urandom), 0, 0, 0, 0,
                       $urandom, $urandom, $urandom, 1'($urandom_range(1)));
            end
            else
            begin
                pick = $urandom_range(99);
                c = mk(ACT_SPARE0, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), $urandom, $urandom, $urandom, 1'($urandom_range(1)));
                if (pick < 25)
                begin
                    c.action = tdrl_pkg::ACT_LOAD_NODE;
                    if ($urandom_range(1)) c.index = 16'($urandom_range(63));
                    c.vx = rand_coord(); c.vy = rand_coord(); c.vz = rand_coord();
                end
                else if (pick < 40)
                begin
                    c.action = tdrl_pkg::ACT_LOAD_ELEM;
                    if ($urandom_range(3) != 0) c.index = 16'($urandom_range(31));
                    for (int v = 0; v < 4; v++)
                        vtx[v] = 16'(nodes_loaded[$urandom_range(nodes_loaded.size() - 1)]);
                    if ($urandom_range(99) < 20) vtx[$urandom_range(3)] = vtx[$urandom_range(3)];
                    c.na = vtx[0]; c.nb = vtx[1]; c.nc = vtx[2]; c.nd = vtx[3];
                end
                else if (pick < 75)
                begin
                    c.action = tdrl_pkg::ACT_ADD_SRC;
                    c.index  = 16'(elems_loaded[$urandom_range(elems_loaded.size() - 1)]);
                    if ($urandom_range(1))
                        c.vx = $signed(32'($urandom_range(1 << 20))) - (1 << 19);
                end
                else if (pick < 96)
                begin
                    c.action = tdrl_pkg::ACT_READ_ACC;
                    if ($urandom_range(3) != 0)
                        c.index = 16'(nodes_loaded[$urandom_range(nodes_loaded.size() - 1)]);
                end
                else
                begin
                    c.action = 3'($urandom_range(5, 7));
                end
            end
            send(c, 0, z0);
        end

        start <= 1'b0;
        while (expected_res.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tdrl_pkg.sv
hw/rtl/tet_dipole_rhs_linear.sv
dv/tb_tet_dipole_rhs_linear.sv
